@@ rtl/accumulator_machine_step_top_macros.svh @@
// ----------------------------------------------------------------------------
// accumulator_machine_step_top_macros
// assertion macros used by the accumulator machine rtl
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_MACHINE_STEP_TOP_MACROS_SVH
`define ACCUMULATOR_MACHINE_STEP_TOP_MACROS_SVH

`ifndef SYNTHESIS

// checked property, ignored while reset is high
`define AMP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked property, also during reset
`define AMP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define AMP_ASSERT(lbl, prop, msg)
`define AMP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/amp_pkg.sv @@
// ----------------------------------------------------------------------------
// amp_pkg
// types and constants of the accumulator machine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package amp_pkg;

   // store sizes, fixed by the 8-bit address fields
   localparam int MEM_DEPTH = 256;
   localparam int INP_DEPTH = 256;

   // item operations
   localparam logic [1:0] OPER_EXEC = 2'd0;
   localparam logic [1:0] OPER_WMEM = 2'd1;
   localparam logic [1:0] OPER_WINP = 2'd2;
   localparam logic [1:0] OPER_RMEM = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_HALT = 2'd1;
   localparam logic [1:0] STAT_DIVZ = 2'd2;
   localparam logic [1:0] STAT_BAD  = 2'd3;

   // opcodes
   localparam logic [7:0] OPC_JP   = 8'h00;
   localparam logic [7:0] OPC_JZ   = 8'h10;
   localparam logic [7:0] OPC_JN   = 8'h20;
   localparam logic [7:0] OPC_LV   = 8'h30;
   localparam logic [7:0] OPC_ADD  = 8'h40;
   localparam logic [7:0] OPC_SUB  = 8'h50;
   localparam logic [7:0] OPC_MUL  = 8'h60;
   localparam logic [7:0] OPC_DIV  = 8'h70;
   localparam logic [7:0] OPC_LD   = 8'h80;
   localparam logic [7:0] OPC_MM   = 8'h90;
   localparam logic [7:0] OPC_SC   = 8'hA0;
   localparam logic [7:0] OPC_RS   = 8'hB0;
   localparam logic [7:0] OPC_HM   = 8'hC0;
   localparam logic [7:0] OPC_GD   = 8'hD0;
   localparam logic [7:0] OPC_GS   = 8'hD1;
   localparam logic [7:0] OPC_GDM  = 8'hD2;
   localparam logic [7:0] OPC_EOF  = 8'hDF;
   localparam logic [7:0] OPC_PD   = 8'hE0;
   localparam logic [7:0] OPC_PS   = 8'hE1;
   localparam logic [7:0] OPC_PDM  = 8'hE2;
   localparam logic [7:0] OPC_NOP0 = 8'hF0;
   localparam logic [7:0] OPC_NOP1 = 8'hF1;

   // memory read address source
   typedef enum logic [1:0] {
      RD_PC   = 2'd0,
      RD_PC1  = 2'd1,
      RD_OPND = 2'd2
   } rd_sel_type;

   // controller to datapath
   typedef struct packed {
      logic       accept;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       latch_opc;
      logic       latch_arg;
      logic       div_start;
      logic       commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_div;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/amp_div.sv @@
// ----------------------------------------------------------------------------
// amp_div
// signed 32-bit by unsigned 8-bit divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amp_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [7:0]  divisor,
   output logic             done,
   output logic [31:0]      quotient
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [7:0]  rem_ff;
   logic [31:0] quo_ff;
   logic [7:0]  dvs_ff;
   logic        neg_ff;
   logic [8:0]  shift_in;
   logic        ge_in;

   // restoring step
   assign shift_in = {rem_ff, quo_ff[31]};
   assign ge_in    = shift_in >= {1'b0, dvs_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // magnitude shift register and remainder
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[31];
         quo_ff <= dividend[31] ? (~dividend + 32'd1) : dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge_in ? 8'(shift_in - {1'b0, dvs_ff}) : shift_in[7:0];
         quo_ff <= {quo_ff[30:0], ge_in};
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 32'd1) : quo_ff;

endmodule

`default_nettype wire

@@ rtl/amp_ctrl.sv @@
// ----------------------------------------------------------------------------
// amp_ctrl
// sequencer for fetch, operand read, execute and divide
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "accumulator_machine_step_top_macros.svh"

module amp_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [1:0]       req_operation,
   output logic                  req_stall,
   input  wire amp_pkg::sts_type sts,
   input  wire logic             div_done,
   output amp_pkg::cmd_type      cmd
);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_FETCH_ARG = 5'b00010,
      ST_FETCH_MEM = 5'b00100,
      ST_EXEC      = 5'b01000,
      ST_DIVIDE    = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      div_ok_ff, div_ok_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      div_ok_in = div_ok_ff;
      cmd       = '0;
      cmd.rd_sel = amp_pkg::RD_PC;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = amp_pkg::RD_PC;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_operation == amp_pkg::OPER_EXEC) ? ST_FETCH_ARG
                                                                   : ST_FETCH_MEM;
            end
         end
         ST_FETCH_ARG: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = amp_pkg::RD_PC1;
            cmd.latch_opc = 1'b1;
            state_in      = ST_FETCH_MEM;
         end
         ST_FETCH_MEM: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = amp_pkg::RD_OPND;
            cmd.latch_arg = 1'b1;
            state_in      = ST_EXEC;
         end
         ST_EXEC: begin
            if (sts.need_div && !div_ok_ff) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end else if (sts.rsp_free) begin
               cmd.commit = 1'b1;
               div_ok_in  = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               div_ok_in = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         div_ok_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         div_ok_ff <= div_ok_in;
      end
   end

   // checks
   `AMP_ASSERT(a_accept_leaves_idle, cmd.accept |=> state_ff != ST_IDLE, "accept did not start item")
   `AMP_ASSERT(a_commit_to_idle, cmd.commit |=> state_ff == ST_IDLE && !div_ok_ff, "commit did not finish item")
   `AMP_ASSERT(a_div_start_once, cmd.div_start |=> state_ff == ST_DIVIDE && !cmd.div_start, "divide start misplaced")
   `AMP_ASSERT(a_no_commit_mid_divide, state_ff == ST_DIVIDE |-> !cmd.commit && !cmd.accept, "activity during divide")

endmodule

`default_nettype wire

@@ rtl/amp_dp.sv @@
// ----------------------------------------------------------------------------
// amp_dp
// datapath: memories, machine registers, execute logic and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amp_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [8:0]          csr_wr_data,
   input  wire logic [1:0]          req_operation,
   input  wire logic [7:0]          req_address,
   input  wire logic [7:0]          req_data,
   input  wire amp_pkg::cmd_type    cmd,
   output amp_pkg::sts_type         sts,
   output logic [31:0]              div_dividend,
   output logic [7:0]               div_divisor,
   input  wire logic [31:0]         div_quotient,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [7:0]               rsp_pc,
   output logic signed [31:0]       rsp_accumulator,
   output logic [7:0]               rsp_read_data,
   output logic                     rsp_output_valid,
   output logic [15:0]              rsp_output_position,
   output logic [7:0]               rsp_output_byte,
   output logic [1:0]               rsp_status,
   output logic [7:0]               rsp_halt_code
);

   // machine state
   logic [7:0]  pc_ff;
   logic [31:0] acc_ff;
   logic [15:0] ic_ff;
   logic [15:0] oc_ff;
   logic [8:0]  in_len_ff;
   logic [7:0]  pc_in;
   logic [31:0] acc_in;
   logic [15:0] ic_in;
   logic [15:0] oc_in;

   // item and fetched bytes
   logic [1:0]  oper_ff;
   logic [7:0]  addr_ff;
   logic [7:0]  data_ff;
   logic [7:0]  opc_ff;
   logic [7:0]  arg_ff;

   // main memory with per-entry valid bits
   logic [7:0]                   mem_ff [amp_pkg::MEM_DEPTH];
   logic [amp_pkg::MEM_DEPTH-1:0] mem_vld_ff;
   logic [7:0]                   rd_ff;
   logic                         rdv_ff;
   logic [7:0]                   rd_addr;
   logic                         mem_we;
   logic [7:0]                   mem_wa;
   logic [7:0]                   mem_wd;
   logic [7:0]                   mbyte;

   // input stream store
   logic [7:0] inp_ff [amp_pkg::INP_DEPTH];
   logic [7:0] inp_rd_ff;
   logic       inp_we;
   logic [7:0] ibyte;

   // result
   logic        rsp_valid_ff;
   logic [7:0]  rsp_pc_ff, rsp_rdata_ff, rsp_obyte_ff, rsp_hcode_ff;
   logic [31:0] rsp_acc_ff;
   logic        rsp_ovalid_ff;
   logic [15:0] rsp_opos_ff;
   logic [1:0]  rsp_stat_ff;
   logic [7:0]  rdata_in, obyte_in, hcode_in;
   logic        ovalid_in;
   logic [15:0] opos_in;
   logic [1:0]  stat_in;
   logic [7:0]  nxt_pc;
   logic [31:0] prod;

   assign mbyte  = rdv_ff ? rd_ff : 8'd0;
   assign ibyte  = (ic_ff < {7'd0, in_len_ff} && ic_ff[15:8] == 8'd0) ? inp_rd_ff : 8'd0;
   assign nxt_pc = pc_ff + 8'd2;
   assign prod   = acc_ff * {24'd0, mbyte};

   // read address select
   always_comb begin
      case (cmd.rd_sel)
         amp_pkg::RD_PC:  rd_addr = pc_ff;
         amp_pkg::RD_PC1: rd_addr = pc_ff + 8'd1;
         amp_pkg::RD_OPND: begin
            if (oper_ff != amp_pkg::OPER_EXEC) begin
               rd_addr = addr_ff;
            end else if (opc_ff == amp_pkg::OPC_PDM) begin
               rd_addr = acc_ff[7:0];
            end else begin
               rd_addr = mbyte;
            end
         end
         default: rd_addr = pc_ff;
      endcase
   end

   // item and fetch latches
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         oper_ff <= req_operation;
         addr_ff <= req_address;
         data_ff <= req_data;
      end
      if (cmd.latch_opc) begin
         opc_ff <= mbyte;
      end
      if (cmd.latch_arg) begin
         arg_ff <= mbyte;
      end
   end

   // main memory
   always_ff @(posedge clock) begin
      if (mem_we && cmd.commit) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_vld_ff <= '0;
         rdv_ff     <= 1'b0;
      end else begin
         if (mem_we && cmd.commit) begin
            mem_vld_ff[mem_wa] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rdv_ff <= mem_vld_ff[rd_addr];
         end
      end
   end

   // input store, read at the input counter
   always_ff @(posedge clock) begin
      if (inp_we && cmd.commit) begin
         inp_ff[addr_ff] <= data_ff;
      end
      inp_rd_ff <= inp_ff[ic_ff[7:0]];
   end

   // execute
   always_comb begin
      pc_in     = pc_ff;
      acc_in    = acc_ff;
      ic_in     = ic_ff;
      oc_in     = oc_ff;
      mem_we    = 1'b0;
      mem_wa    = arg_ff;
      mem_wd    = acc_ff[7:0];
      inp_we    = 1'b0;
      rdata_in  = 8'd0;
      ovalid_in = 1'b0;
      opos_in   = 16'd0;
      obyte_in  = 8'd0;
      stat_in   = amp_pkg::STAT_OK;
      hcode_in  = 8'd0;
      case (oper_ff)
         amp_pkg::OPER_WMEM: begin
            mem_we = 1'b1;
            mem_wa = addr_ff;
            mem_wd = data_ff;
         end
         amp_pkg::OPER_WINP: inp_we = 1'b1;
         amp_pkg::OPER_RMEM: rdata_in = mbyte;
         default: begin
            pc_in = nxt_pc;
            unique case (opc_ff) inside
               amp_pkg::OPC_JP, amp_pkg::OPC_RS: pc_in = arg_ff;
               amp_pkg::OPC_JZ: begin
                  if (acc_ff == 32'd0) pc_in = arg_ff;
               end
               amp_pkg::OPC_JN: begin
                  if (acc_ff[31]) pc_in = arg_ff;
               end
               amp_pkg::OPC_LV:  acc_in = {24'd0, arg_ff};
               amp_pkg::OPC_ADD: acc_in = acc_ff + {24'd0, mbyte};
               amp_pkg::OPC_SUB: acc_in = acc_ff - {24'd0, mbyte};
               amp_pkg::OPC_MUL: acc_in = prod;
               amp_pkg::OPC_DIV: begin
                  if (mbyte == 8'd0) begin
                     stat_in = amp_pkg::STAT_DIVZ;
                  end else begin
                     acc_in = div_quotient;
                  end
               end
               amp_pkg::OPC_LD: acc_in = {24'd0, mbyte};
               amp_pkg::OPC_MM: mem_we = 1'b1;
               amp_pkg::OPC_SC: begin
                  mem_we = 1'b1;
                  mem_wa = arg_ff + 8'd1;
                  mem_wd = nxt_pc;
                  pc_in  = arg_ff + 8'd2;
               end
               amp_pkg::OPC_HM: begin
                  hcode_in = mbyte;
                  stat_in  = amp_pkg::STAT_HALT;
               end
               amp_pkg::OPC_GD: begin
                  acc_in = {{24{ibyte[7]}}, ibyte};
                  ic_in  = ic_ff + 16'd1;
               end
               amp_pkg::OPC_GS: ic_in = {8'd0, mbyte};
               amp_pkg::OPC_GDM: begin
                  mem_we = 1'b1;
                  mem_wa = acc_ff[7:0];
                  mem_wd = ibyte;
                  ic_in  = ic_ff + 16'd1;
               end
               amp_pkg::OPC_EOF: begin
                  if (({1'b0, ic_ff} + 17'd1) >= {8'd0, in_len_ff}) pc_in = arg_ff;
               end
               amp_pkg::OPC_PD, amp_pkg::OPC_PDM: begin
                  ovalid_in = 1'b1;
                  opos_in   = oc_ff;
                  obyte_in  = (opc_ff == amp_pkg::OPC_PD) ? acc_ff[7:0] : mbyte;
                  oc_in     = oc_ff + 16'd1;
               end
               amp_pkg::OPC_PS: oc_in = {8'd0, mbyte};
               amp_pkg::OPC_NOP0, amp_pkg::OPC_NOP1: ;
               default: begin
                  pc_in   = pc_ff;
                  stat_in = amp_pkg::STAT_BAD;
               end
            endcase
         end
      endcase
   end

   // architectural registers and config
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         acc_ff    <= '0;
         ic_ff     <= '0;
         oc_ff     <= '0;
         in_len_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            in_len_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            pc_ff  <= pc_in;
            acc_ff <= acc_in;
            ic_ff  <= ic_in;
            oc_ff  <= oc_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_pc_ff     <= pc_in;
         rsp_acc_ff    <= acc_in;
         rsp_rdata_ff  <= rdata_in;
         rsp_ovalid_ff <= ovalid_in;
         rsp_opos_ff   <= opos_in;
         rsp_obyte_ff  <= obyte_in;
         rsp_stat_ff   <= stat_in;
         rsp_hcode_ff  <= hcode_in;
      end
   end

   // status and divider operands
   assign sts.need_div = (oper_ff == amp_pkg::OPER_EXEC) && (opc_ff == amp_pkg::OPC_DIV)
                         && (mbyte != 8'd0);
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign div_dividend = acc_ff;
   assign div_divisor  = mbyte;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pc              = rsp_pc_ff;
   assign rsp_accumulator     = rsp_acc_ff;
   assign rsp_read_data       = rsp_rdata_ff;
   assign rsp_output_valid    = rsp_ovalid_ff;
   assign rsp_output_position = rsp_opos_ff;
   assign rsp_output_byte     = rsp_obyte_ff;
   assign rsp_status          = rsp_stat_ff;
   assign rsp_halt_code       = rsp_hcode_ff;

endmodule

`default_nettype wire

@@ rtl/accumulator_machine_step_top.sv @@
// ----------------------------------------------------------------------------
// accumulator_machine_step_top
// one step of a 256-byte accumulator machine per request item
// ----------------------------------------------------------------------------
// Items are taken one at a time, and the next request is taken as soon as the
// previous one has been placed in the response register, even if that response
// is still stalled. Memory write, input write and memory read items pass through
// operand read and execute; an execute item first fetches its argument, because
// the opcode, operand and data byte come one after another out of the single read
// port of the byte memory. A divide with nonzero divisor also runs the bit-serial
// divider (one quotient bit per cycle). Memory is cleared by per-byte valid bits,
// so the block is ready in the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module accumulator_machine_step_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [8:0]  csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_address,
   input  wire logic [7:0]  req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_pc,
   output logic signed [31:0] rsp_accumulator,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_output_valid,
   output logic [15:0]      rsp_output_position,
   output logic [7:0]       rsp_output_byte,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_halt_code
);

   amp_pkg::cmd_type cmd;
   amp_pkg::sts_type sts;
   logic             div_done;
   logic [31:0]      div_dividend;
   logic [7:0]       div_divisor;
   logic [31:0]      div_quotient;

   // sequencer
   amp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .sts           (sts),
      .div_done      (div_done),
      .cmd           (cmd)
   );

   // datapath
   amp_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_operation       (req_operation),
      .req_address         (req_address),
      .req_data            (req_data),
      .cmd                 (cmd),
      .sts                 (sts),
      .div_dividend        (div_dividend),
      .div_divisor         (div_divisor),
      .div_quotient        (div_quotient),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pc              (rsp_pc),
      .rsp_accumulator     (rsp_accumulator),
      .rsp_read_data       (rsp_read_data),
      .rsp_output_valid    (rsp_output_valid),
      .rsp_output_position (rsp_output_position),
      .rsp_output_byte     (rsp_output_byte),
      .rsp_status          (rsp_status),
      .rsp_halt_code       (rsp_halt_code)
   );

   // serial divider
   amp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

endmodule

`default_nettype wire
